// ===== design/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types, codes and constants of the transmit completion tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tct_pkg;

	// Default number of FIFO entries
	localparam int unsigned FIFO_DEPTH_DEF = 32;

	// Field widths
	localparam int unsigned COOKIE_W = 32;
	localparam int unsigned IDX_W    = 16;
	localparam int unsigned BYTES_W  = 16;
	localparam int unsigned FREE_W   = 6;
	localparam int unsigned TOTAL_W  = 64;

	// Half-window of the 16-bit modular index compare
	localparam logic [IDX_W-1:0] HALF_WINDOW = 16'h8000;

	// Command codes
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_HARVEST = 2'd1;
	localparam logic [1:0] CMD_DRAIN   = 2'd2;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_PUSHED = 3'd0,
		KIND_FULL   = 3'd1,
		KIND_DONE   = 3'd2,
		KIND_DROP   = 3'd3,
		KIND_NONE   = 3'd4
	} kind_t;

	// One stored FIFO entry
	typedef struct packed {
		logic [COOKIE_W-1:0] cookie;
		logic [IDX_W-1:0]    end_idx;
		logic [BYTES_W-1:0]  nbytes;
	} entry_t;

	// One result, without its last flag
	typedef struct packed {
		kind_t               kind;
		logic [COOKIE_W-1:0] cookie;
		logic [BYTES_W-1:0]  nbytes;
		logic [FREE_W-1:0]   free;
		logic [TOTAL_W-1:0]  pk_tot;
		logic [TOTAL_W-1:0]  by_tot;
		logic [TOTAL_W-1:0]  dr_tot;
	} rsp_t;

endpackage

`default_nettype wire

// ===== design/tct_req_if.sv =====
// ----------------------------------------------------------------------------
// tct_req_if
// Request channel of the completion tracker: valid/ready plus command fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] cookie;
	logic [15:0] end_index;
	logic [15:0] byte_count;
	logic [15:0] hw_consumer;

	modport source (
		output valid, cmd, cookie, end_index, byte_count, hw_consumer,
		input  ready
	);
	modport sink (
		input  valid, cmd, cookie, end_index, byte_count, hw_consumer,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/tct_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tct_rsp_if
// Result channel of the completion tracker: valid/ready plus result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] cookie_out;
	logic [15:0] bytes_out;
	logic        last;
	logic [5:0]  free_slots;
	logic [63:0] packets_total;
	logic [63:0] bytes_total;
	logic [63:0] dropped_total;

	modport source (
		output valid, kind, cookie_out, bytes_out, last, free_slots,
		       packets_total, bytes_total, dropped_total,
		input  ready
	);
	modport sink (
		input  valid, kind, cookie_out, bytes_out, last, free_slots,
		       packets_total, bytes_total, dropped_total,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/tx_completion_tracker_core.sv =====
// ----------------------------------------------------------------------------
// tx_completion_tracker_core
// FIFO of pending transmit completions with modular index harvest and drain.
// ----------------------------------------------------------------------------
// A push returns one result (pushed or full). A harvest or drain that finds
// the FIFO empty, the block detached, or an unused command also returns a
// single result. Otherwise the request enters a pop loop that reads the
// head entry from the entry RAM (registered read) and retires one entry
// per cycle while the result port keeps up; a request that pops n entries
// occupies the block for its accept, n pops and one closing step, and
// returns max(n, 1) results, the last one flagged. The next request is
// taken once the final result sits in the output register. The user must
// write configuration (stack_attached, reset value 1) via cfg_we/cfg_wdata
// only while no request is in flight; the block does not enforce this.
`default_nettype none

module tx_completion_tracker_core #(
	parameter int unsigned FIFO_DEPTH = tct_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	tct_req_if.sink   req,
	tct_rsp_if.source rsp
);

	localparam int unsigned SLOT_W = $clog2(FIFO_DEPTH);

	logic              stack_attached_q;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr, ram_raddr;
	tct_pkg::entry_t   ram_wdata, ram_rdata;

	// Attach register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_attached_q <= 1'b1;
		end else if (cfg_we) begin
			stack_attached_q <= cfg_wdata;
		end
	end

	// Entry store: cookie, end index and byte count in one word
	tct_ram #(
		.WIDTH ($bits(tct_pkg::entry_t)),
		.DEPTH (FIFO_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer
	tct_ctrl #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.stack_attached (stack_attached_q),
		.req            (req),
		.rsp            (rsp),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata)
	);

endmodule

`default_nettype wire

// ===== design/tct_ram.sv =====
// ----------------------------------------------------------------------------
// tct_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/tct_ctrl.sv =====
// ----------------------------------------------------------------------------
// tct_ctrl
// Command sequencer: FIFO pointers, head compare, pop loop, running totals,
// one-deep hold of the latest pop and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_ctrl #(
	parameter int unsigned FIFO_DEPTH = tct_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          stack_attached,
	tct_req_if.sink                            req,
	tct_rsp_if.source                          rsp,
	output logic                               ram_we,
	output logic      [$clog2(FIFO_DEPTH)-1:0] ram_waddr,
	output tct_pkg::entry_t                    ram_wdata,
	output logic      [$clog2(FIFO_DEPTH)-1:0] ram_raddr,
	input  tct_pkg::entry_t                    ram_rdata
);

	localparam int unsigned SLOT_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(FIFO_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;

	// Pointers: slot plus a phase bit, together counting modulo 2*depth
	logic [SLOT_W-1:0] wr_slot_q, rd_slot_q, rd_slot_d;
	logic              wr_ph_q, rd_ph_q, rd_ph_d;

	logic [tct_pkg::TOTAL_W-1:0] sent_pk_q, sent_by_q, lost_pk_q;
	logic [tct_pkg::TOTAL_W-1:0] sent_pk_nx, sent_by_nx, lost_pk_nx;

	logic                   drain_q, drop_q;
	logic [tct_pkg::IDX_W-1:0] hw_q;

	logic          pend_vld_q;
	tct_pkg::rsp_t pend_q;
	logic          out_vld_q;
	logic          out_last_q;
	tct_pkg::rsp_t out_q;

	logic [CNT_W-1:0] used, free_now;
	logic             empty, full;
	logic             can_emit, accept, push_ok, retire, go_run, imm;
	logic [tct_pkg::IDX_W-1:0] diff;
	logic             reached, nz_bytes;
	logic             want_done, want_drop, finish;
	logic             pop_done, pop_drop, pop, fin;
	tct_pkg::rsp_t    imm_rsp, pop_rsp, fin_rsp;

	// Occupancy from the pointers
	always_comb begin
		if (wr_ph_q == rd_ph_q) begin
			used = CNT_W'(wr_slot_q) - CNT_W'(rd_slot_q);
		end else begin
			used = DEPTH_CNT + CNT_W'(wr_slot_q) - CNT_W'(rd_slot_q);
		end
		free_now = DEPTH_CNT - used;
		empty    = (used == '0);
		full     = (used == DEPTH_CNT);
	end

	// Input handshake and immediate decisions
	assign can_emit  = !out_vld_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && can_emit;
	assign accept    = req.valid && req.ready;

	always_comb begin
		push_ok = 1'b0;
		retire  = 1'b0;
		go_run  = 1'b0;
		unique case (req.cmd) inside
			tct_pkg::CMD_PUSH: begin
				push_ok = !full;
			end
			tct_pkg::CMD_HARVEST, tct_pkg::CMD_DRAIN: begin
				retire = !empty && !stack_attached;
				go_run = !empty && stack_attached;
			end
			default: begin
			end
		endcase
	end
	assign imm = accept && !go_run;

	// Head compare in the 16-bit half-window sense
	assign diff     = hw_q - ram_rdata.end_idx;
	assign reached  = (diff < tct_pkg::HALF_WINDOW);
	assign nz_bytes = (ram_rdata.nbytes != '0);

	// Pop loop decisions
	always_comb begin
		want_done = (state_q == ST_RUN) && !empty && !drop_q && reached;
		want_drop = (state_q == ST_RUN) && !empty && (drop_q || (drain_q && !reached));
		finish    = (state_q == ST_RUN) && !want_done && !want_drop;
		pop_done  = want_done && can_emit;
		pop_drop  = want_drop && can_emit;
		pop       = pop_done || pop_drop;
		fin       = finish && can_emit;
	end

	// Running totals after a pop
	always_comb begin
		sent_pk_nx = sent_pk_q;
		sent_by_nx = sent_by_q;
		lost_pk_nx = lost_pk_q;
		if (pop_done && nz_bytes) begin
			sent_pk_nx = sent_pk_q + tct_pkg::TOTAL_W'(1);
			sent_by_nx = sent_by_q + tct_pkg::TOTAL_W'(ram_rdata.nbytes);
		end
		if (pop_drop && nz_bytes) begin
			lost_pk_nx = lost_pk_q + tct_pkg::TOTAL_W'(1);
		end
	end

	// Read pointer next value; the RAM always reads the upcoming head
	always_comb begin
		rd_slot_d = rd_slot_q;
		rd_ph_d   = rd_ph_q;
		if (pop) begin
			if (rd_slot_q == LAST_SLOT) begin
				rd_slot_d = '0;
				rd_ph_d   = !rd_ph_q;
			end else begin
				rd_slot_d = rd_slot_q + SLOT_W'(1);
			end
		end else if (accept && retire) begin
			rd_slot_d = wr_slot_q;
			rd_ph_d   = wr_ph_q;
		end
	end
	assign ram_raddr = rd_slot_d;

	// Push write port
	assign ram_we            = accept && push_ok;
	assign ram_waddr         = wr_slot_q;
	assign ram_wdata.cookie  = req.cookie;
	assign ram_wdata.end_idx = req.end_index;
	assign ram_wdata.nbytes  = req.byte_count;

	// Result candidates
	always_comb begin
		imm_rsp        = '0;
		imm_rsp.kind   = tct_pkg::KIND_NONE;
		imm_rsp.free   = tct_pkg::FREE_W'(free_now);
		imm_rsp.pk_tot = sent_pk_q;
		imm_rsp.by_tot = sent_by_q;
		imm_rsp.dr_tot = lost_pk_q;
		if (req.cmd == tct_pkg::CMD_PUSH) begin
			imm_rsp.kind = push_ok ? tct_pkg::KIND_PUSHED : tct_pkg::KIND_FULL;
			if (push_ok) begin
				imm_rsp.free = tct_pkg::FREE_W'(free_now - CNT_W'(1));
			end
		end else if (retire) begin
			imm_rsp.free = tct_pkg::FREE_W'(DEPTH_CNT);
		end

		pop_rsp.kind   = pop_drop ? tct_pkg::KIND_DROP : tct_pkg::KIND_DONE;
		pop_rsp.cookie = ram_rdata.cookie;
		pop_rsp.nbytes = ram_rdata.nbytes;
		pop_rsp.free   = tct_pkg::FREE_W'(free_now + CNT_W'(1));
		pop_rsp.pk_tot = sent_pk_nx;
		pop_rsp.by_tot = sent_by_nx;
		pop_rsp.dr_tot = lost_pk_nx;

		if (pend_vld_q) begin
			fin_rsp = pend_q;
		end else begin
			fin_rsp        = '0;
			fin_rsp.kind   = tct_pkg::KIND_NONE;
			fin_rsp.free   = tct_pkg::FREE_W'(free_now);
			fin_rsp.pk_tot = sent_pk_q;
			fin_rsp.by_tot = sent_by_q;
			fin_rsp.dr_tot = lost_pk_q;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_slot_q  <= '0;
			wr_ph_q    <= 1'b0;
			rd_slot_q  <= '0;
			rd_ph_q    <= 1'b0;
			sent_pk_q  <= '0;
			sent_by_q  <= '0;
			lost_pk_q  <= '0;
			drain_q    <= 1'b0;
			drop_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			rd_slot_q <= rd_slot_d;
			rd_ph_q   <= rd_ph_d;
			sent_pk_q <= sent_pk_nx;
			sent_by_q <= sent_by_nx;
			lost_pk_q <= lost_pk_nx;

			if (ram_we) begin
				if (wr_slot_q == LAST_SLOT) begin
					wr_slot_q <= '0;
					wr_ph_q   <= !wr_ph_q;
				end else begin
					wr_slot_q <= wr_slot_q + SLOT_W'(1);
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && go_run) begin
						state_q <= ST_RUN;
						drain_q <= (req.cmd == tct_pkg::CMD_DRAIN);
						drop_q  <= 1'b0;
					end
				end
				ST_RUN: begin
					if (pop_drop) begin
						drop_q <= 1'b1;
					end
					if (pop) begin
						pend_vld_q <= 1'b1;
					end
					if (fin) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (imm || fin || (pop && pend_vld_q)) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept && go_run) begin
			hw_q <= req.hw_consumer;
		end
		if (pop) begin
			pend_q <= pop_rsp;
		end
		if (imm) begin
			out_q      <= imm_rsp;
			out_last_q <= 1'b1;
		end else if (fin) begin
			out_q      <= fin_rsp;
			out_last_q <= 1'b1;
		end else if (pop && pend_vld_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b0;
		end
	end

	// Result port
	assign rsp.valid         = out_vld_q;
	assign rsp.kind          = out_q.kind;
	assign rsp.cookie_out    = out_q.cookie;
	assign rsp.bytes_out     = out_q.nbytes;
	assign rsp.last          = out_last_q;
	assign rsp.free_slots    = out_q.free;
	assign rsp.packets_total = out_q.pk_tot;
	assign rsp.bytes_total   = out_q.by_tot;
	assign rsp.dropped_total = out_q.dr_tot;

	// Occupancy never exceeds the depth
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= DEPTH_CNT)
		else $error("FIFO occupancy above depth");

	// A new request is taken only with no held pop outstanding
	a_ready_clean: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !pend_vld_q)
		else $error("ready while a popped entry is still held");

	// A nothing result always closes its request
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.kind == tct_pkg::KIND_NONE) |-> out_last_q)
		else $error("nothing result without last");

	// Totals move only while popping
	a_tot_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!$stable(sent_pk_q) || !$stable(lost_pk_q)) |-> $past(state_q == ST_RUN))
		else $error("totals changed outside the pop loop");

	// The entry store is written only between requests
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("entry write during pop loop");

endmodule

`default_nettype wire

// ===== tb/sv/tx_completion_tracker_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tx_completion_tracker_core_tb
// Self-checking bench for the transmit completion tracker. A directed part
// covers empty, in-flight, half-window, zero-byte, drop, detached and unused
// command requests. Random phases follow, with sender idling, receiver
// stalls, one long receiver hold-off and pushes that fill the block. A scoreboard
// class predicts every result and checks it field by field.
// ----------------------------------------------------------------------------

module tx_completion_tracker_core_tb;

	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_GAP     = 20;

	// Command code the block does not use
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// One predicted result with its last flag
	typedef struct packed {
		tct_pkg::rsp_t body;
		logic          last;
	} tracker_result_t;

	// Predicts the tracker's results and checks the ones the block returns
	class completion_scoreboard;
		localparam int unsigned DEPTH = tct_pkg::FIFO_DEPTH_DEF;

		logic [tct_pkg::COOKIE_W-1:0] slot_cookie [DEPTH];
		logic [tct_pkg::IDX_W-1:0]    slot_end [DEPTH];
		logic [tct_pkg::BYTES_W-1:0]  slot_bytes [DEPTH];
		int unsigned                  wr_ptr;
		int unsigned                  rd_ptr;
		logic [tct_pkg::TOTAL_W-1:0]  sent_pkts;
		logic [tct_pkg::TOTAL_W-1:0]  sent_octets;
		logic [tct_pkg::TOTAL_W-1:0]  lost_pkts;
		bit                           attached;
		tracker_result_t              owed_results[$];
		int unsigned                  errors;

		function new();
			wr_ptr      = 0;
			rd_ptr      = 0;
			sent_pkts   = '0;
			sent_octets = '0;
			lost_pkts   = '0;
			attached    = 1'b1;
			errors      = 0;
		endfunction

		function int unsigned occupancy();
			return (wr_ptr + 2 * DEPTH - rd_ptr) % (2 * DEPTH);
		endfunction

		function int unsigned free_now();
			int unsigned used;
			used = occupancy();
			return (used >= DEPTH) ? 0 : DEPTH - used;
		endfunction

		// Queue one result, counters and free count taken as they stand now
		function void owe(tct_pkg::kind_t kind, logic [tct_pkg::COOKIE_W-1:0] ck,
				logic [tct_pkg::BYTES_W-1:0] nb);
			tracker_result_t r;
			r.body.kind   = kind;
			r.body.cookie = ck;
			r.body.nbytes = nb;
			r.body.free   = tct_pkg::FREE_W'(free_now());
			r.body.pk_tot = sent_pkts;
			r.body.by_tot = sent_octets;
			r.body.dr_tot = lost_pkts;
			r.last        = 1'b0;
			owed_results.push_back(r);
		endfunction

		// Pop every head entry the consumer snapshot has passed
		function void harvest_completed(logic [tct_pkg::IDX_W-1:0] hw);
			int unsigned               slot;
			logic [tct_pkg::IDX_W-1:0] distance;
			if (occupancy() == 0)
				return;
			if (!attached) begin
				rd_ptr = wr_ptr;
				return;
			end
			while (occupancy() != 0) begin
				slot     = rd_ptr % DEPTH;
				distance = hw - slot_end[slot];
				if (distance >= tct_pkg::HALF_WINDOW)
					break;
				if (slot_bytes[slot] != 0) begin
					sent_pkts   = sent_pkts + tct_pkg::TOTAL_W'(1);
					sent_octets = sent_octets + tct_pkg::TOTAL_W'(slot_bytes[slot]);
				end
				rd_ptr = (rd_ptr + 1) % (2 * DEPTH);
				owe(tct_pkg::KIND_DONE, slot_cookie[slot], slot_bytes[slot]);
			end
		endfunction

		function void accept_request(logic [1:0] cmd, logic [tct_pkg::COOKIE_W-1:0] ck,
				logic [tct_pkg::IDX_W-1:0] endi, logic [tct_pkg::BYTES_W-1:0] nb,
				logic [tct_pkg::IDX_W-1:0] hw);
			int unsigned first;
			int unsigned slot;
			first = owed_results.size();
			case (cmd)
				tct_pkg::CMD_PUSH: begin
					if (free_now() == 0) begin
						owe(tct_pkg::KIND_FULL, '0, '0);
					end else begin
						slot              = wr_ptr % DEPTH;
						slot_cookie[slot] = ck;
						slot_end[slot]    = endi;
						slot_bytes[slot]  = nb;
						wr_ptr            = (wr_ptr + 1) % (2 * DEPTH);
						owe(tct_pkg::KIND_PUSHED, '0, '0);
					end
				end
				tct_pkg::CMD_HARVEST: begin
					harvest_completed(hw);
				end
				tct_pkg::CMD_DRAIN: begin
					harvest_completed(hw);
					if (attached) begin
						while (occupancy() != 0) begin
							slot = rd_ptr % DEPTH;
							if (slot_bytes[slot] != 0)
								lost_pkts = lost_pkts + tct_pkg::TOTAL_W'(1);
							rd_ptr = (rd_ptr + 1) % (2 * DEPTH);
							owe(tct_pkg::KIND_DROP, slot_cookie[slot], slot_bytes[slot]);
						end
					end
				end
				default: ;
			endcase
			if (owed_results.size() == first)
				owe(tct_pkg::KIND_NONE, '0, '0);
			owed_results[owed_results.size() - 1].last = 1'b1;
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [2:0] kind, logic [tct_pkg::COOKIE_W-1:0] ck,
				logic [tct_pkg::BYTES_W-1:0] nb, logic last,
				logic [tct_pkg::FREE_W-1:0] free_slots, logic [tct_pkg::TOTAL_W-1:0] pk,
				logic [tct_pkg::TOTAL_W-1:0] bt, logic [tct_pkg::TOTAL_W-1:0] dr);
			tracker_result_t want;
			if (owed_results.size() == 0) begin
				$error("result with no request outstanding: kind %0d cookie %0h", kind, ck);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			compare_field("kind", 64'(want.body.kind), 64'(kind));
			compare_field("cookie_out", 64'(want.body.cookie), 64'(ck));
			compare_field("bytes_out", 64'(want.body.nbytes), 64'(nb));
			compare_field("last", 64'(want.last), 64'(last));
			compare_field("free_slots", 64'(want.body.free), 64'(free_slots));
			compare_field("packets_total", want.body.pk_tot, pk);
			compare_field("bytes_total", want.body.by_tot, bt);
			compare_field("dropped_total", want.body.dr_tot, dr);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic cfg_wdata;

	tct_req_if req_if();
	tct_rsp_if rsp_if();

	completion_scoreboard tracker;

	int unsigned               sender_idle_pct = 0;
	int unsigned               rsp_stall_pct = 0;
	int unsigned               hold_epoch = 0;
	logic [tct_pkg::IDX_W-1:0] ring_tail;
	logic [tct_pkg::IDX_W-1:0] ring_hw;

	tx_completion_tracker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	always #4 clk = ~clk;

	// Result receiver: random stalls plus an occasional long hold-off
	initial begin
		int unsigned seen_epoch;
		int unsigned hold_left;
		seen_epoch = 0;
		hold_left  = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_epoch != seen_epoch) begin
				seen_epoch = hold_epoch;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	// Handshake monitor: check returned results, predict accepted requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready)
				tracker.check_result(rsp_if.kind, rsp_if.cookie_out, rsp_if.bytes_out,
					rsp_if.last, rsp_if.free_slots, rsp_if.packets_total,
					rsp_if.bytes_total, rsp_if.dropped_total);
			if (req_if.valid && req_if.ready)
				tracker.accept_request(req_if.cmd, req_if.cookie, req_if.end_index,
					req_if.byte_count, req_if.hw_consumer);
		end
	end

	// Offer one request, after a random idle gap, and hold it until taken
	task automatic send_request(input logic [1:0] cmd,
			input logic [tct_pkg::COOKIE_W-1:0] ck, input logic [tct_pkg::IDX_W-1:0] endi,
			input logic [tct_pkg::BYTES_W-1:0] nb, input logic [tct_pkg::IDX_W-1:0] hw);
		int unsigned gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.cmd         <= cmd;
		req_if.cookie      <= ck;
		req_if.end_index   <= endi;
		req_if.byte_count  <= nb;
		req_if.hw_consumer <= hw;
		do @(posedge clk); while (!req_if.ready);
	endtask

	// Stop offering and wait until every predicted result has come back
	task automatic wait_idle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (tracker.owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_attached(input bit value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.attached = value;
	endtask

	// Mostly well-formed ring traffic, with some fully random requests
	task automatic random_request();
		int unsigned                 pick;
		int unsigned                 span;
		logic [tct_pkg::BYTES_W-1:0] nb;
		pick = $urandom_range(99);
		if (pick < 55) begin
			ring_tail = ring_tail + tct_pkg::IDX_W'($urandom_range(4, 1));
			nb = ($urandom_range(9) == 0) ? '0 : tct_pkg::BYTES_W'($urandom);
			send_request(tct_pkg::CMD_PUSH, $urandom, ring_tail, nb,
				tct_pkg::IDX_W'($urandom));
		end else if (pick < 85) begin
			span    = 32'(tct_pkg::IDX_W'(ring_tail - ring_hw));
			ring_hw = ring_hw + tct_pkg::IDX_W'($urandom_range(span));
			send_request(tct_pkg::CMD_HARVEST, $urandom, tct_pkg::IDX_W'($urandom),
				tct_pkg::BYTES_W'($urandom), ring_hw);
		end else if (pick < 93) begin
			send_request(tct_pkg::CMD_DRAIN, $urandom, tct_pkg::IDX_W'($urandom),
				tct_pkg::BYTES_W'($urandom), ring_hw);
		end else begin
			send_request(2'($urandom_range(3)), $urandom, tct_pkg::IDX_W'($urandom),
				tct_pkg::BYTES_W'($urandom), tct_pkg::IDX_W'($urandom));
		end
	endtask

	task automatic random_phase(input int unsigned count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		sender_idle_pct = idle_pct;
		rsp_stall_pct   = stall_pct;
		repeat (count) random_request();
	endtask

	// Run limit
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Stimulus
	initial begin
		tracker = new();
		cfg_we             = 1'b0;
		cfg_wdata          = 1'b0;
		req_if.valid       = 1'b0;
		req_if.cmd         = tct_pkg::CMD_PUSH;
		req_if.cookie      = '0;
		req_if.end_index   = '0;
		req_if.byte_count  = '0;
		req_if.hw_consumer = '0;
		ring_tail = 16'hFFE0;
		ring_hw   = 16'hFFE0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty FIFO, unused command
		send_request(tct_pkg::CMD_HARVEST, '0, '0, '0, 16'h0000);
		send_request(tct_pkg::CMD_DRAIN, '1, '1, '1, 16'hFFFF);
		send_request(CMD_UNUSED, 32'h5A5A_A5A5, 16'h1234, 16'h4321, 16'h8000);
		// Field extremes, a zero-byte entry between them
		send_request(tct_pkg::CMD_PUSH, 32'hFFFF_FFFF, 16'h0010, 16'hFFFF, '0);
		send_request(tct_pkg::CMD_PUSH, 32'h0000_0000, 16'h8010, 16'h0000, '1);
		send_request(tct_pkg::CMD_PUSH, 32'hA5A5_5A5A, 16'hFFFF, 16'h0001, '0);
		// Head still in flight, then just inside the half window
		send_request(tct_pkg::CMD_HARVEST, '0, '0, '0, 16'h000F);
		send_request(tct_pkg::CMD_HARVEST, '0, '0, '0, 16'h800F);
		send_request(tct_pkg::CMD_HARVEST, '0, '0, '0, 16'h8010);
		send_request(tct_pkg::CMD_PUSH, 32'h1234_5678, 16'h0000, 16'h8000, '0);
		// Exactly half a window away: not reached, both dropped
		send_request(tct_pkg::CMD_DRAIN, '0, '0, '0, 16'h7FFF);

		// Detached: silent retire on harvest and drain
		write_attached(1'b0);
		send_request(tct_pkg::CMD_PUSH, 32'h0000_0011, 16'h0001, 16'h0040, '0);
		send_request(tct_pkg::CMD_PUSH, 32'h0000_0022, 16'h0002, 16'h0000, '0);
		send_request(tct_pkg::CMD_HARVEST, '0, '0, '0, 16'h7000);
		send_request(tct_pkg::CMD_PUSH, 32'h0000_0033, 16'h0003, 16'h0080, '0);
		send_request(tct_pkg::CMD_DRAIN, '0, '0, '0, 16'h0000);
		send_request(tct_pkg::CMD_HARVEST, '0, '0, '0, 16'h0000);
		write_attached(1'b1);

		random_phase(20, 0, 0);
		random_phase(20, 70, 0);
		random_phase(20, 0, 70);
		write_attached(1'b0);
		random_phase(20, 18, 18);
		write_attached(1'b1);
		random_phase(20, 18, 18);

		// Long receiver hold-off while pushes wait, then enough pushes to fill and overflow
		sender_idle_pct = 0;
		rsp_stall_pct   = 0;
		send_request(tct_pkg::CMD_DRAIN, '0, '0, '0, ring_hw);
		hold_epoch++;
		repeat (40) begin
			ring_tail = ring_tail + tct_pkg::IDX_W'($urandom_range(4, 1));
			send_request(tct_pkg::CMD_PUSH, $urandom, ring_tail,
				tct_pkg::BYTES_W'($urandom), '0);
		end
		ring_hw = ring_tail;
		send_request(tct_pkg::CMD_HARVEST, '0, '0, '0, ring_hw);
		send_request(tct_pkg::CMD_DRAIN, '0, '0, '0, ring_hw);

		wait_idle();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
design/tct_pkg.sv
design/tct_req_if.sv
design/tct_rsp_if.sv
design/tct_ram.sv
design/tct_ctrl.sv
design/tx_completion_tracker_core.sv
tb/sv/tx_completion_tracker_core_tb.sv
